// ----- rtl/core/bhm_pkg.sv -----
// bhm_pkg: shared types and constants of the BCC Heisenberg Metropolis block.
// Used by the top level, the port checker and the testbench; depends on nothing.
package bhm_pkg;

    localparam int SPIN_W       = 16;
    localparam int DELTA_W      = 48;
    localparam int TOTAL_W      = 56;
    localparam int MAGNET_OUT_W = 29;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int KT_W         = 31;
    localparam int NLU_W        = 24;

    // Register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_Z  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIAL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_KT       = 3'd6;

    localparam logic signed [SPIN_W-1:0] SPIN_ONE  = 16'sd16384;
    localparam logic signed [SPIN_W-1:0] SPIN_ZERO = 16'sd0;

    // One stored spin, x in the low bits
    typedef struct packed {
        logic signed [SPIN_W-1:0] z;
        logic signed [SPIN_W-1:0] y;
        logic signed [SPIN_W-1:0] x;
    } spin_t;

    localparam int SPIN_WORD_W = 3 * SPIN_W;

endpackage

// ----- rtl/core/bhm_ram.sv -----
// bhm_ram: generic single-port synchronous RAM with a registered read.
// No dependencies.
module bhm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/bcc_heisenberg_metropolis_update.sv -----
// bcc_heisenberg_metropolis_update: Metropolis single-spin update on a periodic BCC lattice.
// Depends on bhm_pkg and bhm_ram (spin store).
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, site_*, sublattice,  | item in
//           | proposed_*, neg_log_uniform              |
//   out     | out_valid, out_stall, accepted, energy_*,| item out
//           | magnet_*                                 |
//   cfg     | cfg_write, cfg_index, cfg_data           | write only
//
// An item moves from acceptance through these states: reads of its neighbors and
// of itself through the single spin-store port, the shared multiplier (8 steps per
// component), the threshold and the decision, write-back, and back to idle, where
// the next item is taken.
// After reset a clearing pass writes +z into all 2*LATTICE_SIDE^3 entries, one
// per cycle (8192 entries at the default size); no item is taken meanwhile.
// A stalled result is held in the output register; the next item is taken and
// worked on meanwhile, and waits before write-back until the result is taken.
module bcc_heisenberg_metropolis_update #(
    parameter int LATTICE_SIDE = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [3:0]                               site_x,
    input  logic [3:0]                               site_y,
    input  logic [3:0]                               site_z,
    input  logic                                     sublattice,
    input  logic signed [bhm_pkg::SPIN_W-1:0]        proposed_x,
    input  logic signed [bhm_pkg::SPIN_W-1:0]        proposed_y,
    input  logic signed [bhm_pkg::SPIN_W-1:0]        proposed_z,
    input  logic [bhm_pkg::NLU_W-1:0]                neg_log_uniform,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     accepted,
    output logic signed [bhm_pkg::DELTA_W-1:0]       energy_delta,
    output logic signed [bhm_pkg::TOTAL_W-1:0]       energy_total_change,
    output logic signed [bhm_pkg::MAGNET_OUT_W-1:0]  magnet_x,
    output logic signed [bhm_pkg::MAGNET_OUT_W-1:0]  magnet_y,
    output logic signed [bhm_pkg::MAGNET_OUT_W-1:0]  magnet_z,
    input  logic                                     cfg_write,
    input  logic [bhm_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [bhm_pkg::CFG_W-1:0]                cfg_data
);

    localparam int CELLS = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;
    localparam int DEPTH = 2 * CELLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(LATTICE_SIDE);
    localparam int MW    = AW + 17;
    localparam int MWO   = (MW > bhm_pkg::MAGNET_OUT_W) ? MW : bhm_pkg::MAGNET_OUT_W;
    localparam int PW    = 72;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_CALC  = 3'd3;
    localparam logic [2:0] ST_THR   = 3'd4;
    localparam logic [2:0] ST_DEC   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [3:0] RD_LAST = 4'd14;
    localparam logic [3:0] RD_END  = 4'd15;

    localparam logic signed [PW-1:0] MAX32 = 72'sh7FFF_FFFF;
    localparam logic signed [PW-1:0] MIN32 = -MAX32 - 72'sd1;
    localparam logic signed [PW-1:0] MAX40 = 72'sh7F_FFFF_FFFF;
    localparam logic signed [PW-1:0] MIN40 = -MAX40 - 72'sd1;
    localparam logic signed [56:0] MAX56 = 57'sh7F_FFFF_FFFF_FFFF;
    localparam logic signed [56:0] MIN56 = -MAX56 - 57'sd1;
    localparam logic signed [MWO-1:0] MAG_Z_RESET = MWO'(DEPTH * 16384);

    // ---------------- helper functions ----------------
    function automatic logic [CW-1:0] coord_mod(input logic [3:0] v);
        logic [5:0] t;
        t = {2'b00, v};
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 6'(LATTICE_SIDE))
            begin
                t = t - 6'(LATTICE_SIDE);
            end
        end
        return t[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] coord_inc(input logic [CW-1:0] c);
        return (c == CW'(LATTICE_SIDE - 1)) ? '0 : c + CW'(1);
    endfunction

    function automatic logic [CW-1:0] coord_dec(input logic [CW-1:0] c);
        return (c == '0) ? CW'(LATTICE_SIDE - 1) : c - CW'(1);
    endfunction

    function automatic logic [AW-1:0] site_addr(input logic sub, input logic [CW-1:0] x,
                                                input logic [CW-1:0] y, input logic [CW-1:0] z);
        int a;
        a = int'(sub) * CELLS + int'(x) * LATTICE_SIDE * LATTICE_SIDE
          + int'(y) * LATTICE_SIDE + int'(z);
        return AW'(a);
    endfunction

    function automatic logic signed [39:0] sat32(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        r = (v > MAX32) ? MAX32 : ((v < MIN32) ? MIN32 : v);
        return r[39:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] r;
        r = (v > MAX40) ? MAX40 : ((v < MIN40) ? MIN40 : v);
        return r[39:0];
    endfunction

    // ---------------- registers ----------------
    logic [2:0]  state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [3:0]  cnt_reg;
    logic [1:0]  comp_reg;
    logic [2:0]  step_reg;
    logic        rd_vld_reg;
    logic [3:0]  rd_n_reg;

    logic signed [31:0] coupling_reg, axial_reg, scale_reg;
    logic signed [31:0] field_reg [3];
    logic [bhm_pkg::KT_W-1:0] kt_reg;

    logic [CW-1:0] bx_reg, by_reg, bz_reg;
    logic          sub_reg;
    logic signed [bhm_pkg::SPIN_W-1:0] prop_reg [3];
    logic [bhm_pkg::NLU_W-1:0] nlu_reg;

    logic signed [18:0] nn_reg [3];
    logic signed [17:0] n4_reg [3];
    logic signed [16:0] zs_reg [3];
    logic signed [bhm_pkg::SPIN_W-1:0] old_reg [3];

    logic signed [PW-1:0] p_reg;
    logic signed [39:0]   t_reg;
    logic signed [bhm_pkg::DELTA_W-1:0] dacc_reg;
    logic signed [bhm_pkg::DELTA_W-1:0] delta_reg;
    logic        acc_reg;

    logic signed [bhm_pkg::TOTAL_W-1:0] energy_reg;
    logic signed [MWO-1:0] mag_reg [3];

    logic        out_valid_reg;
    logic        out_acc_reg;
    logic signed [bhm_pkg::DELTA_W-1:0] out_delta_reg;
    logic signed [bhm_pkg::TOTAL_W-1:0] out_total_reg;
    logic signed [bhm_pkg::MAGNET_OUT_W-1:0] out_mag_reg [3];

    // ---------------- handshakes ----------------
    logic in_fire, done_fire;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // ---------------- neighbor addresses ----------------
    logic [CW-1:0] xs1, ys1, zs1;
    logic [AW-1:0] rd_addr, self_addr;
    assign xs1 = sub_reg ? coord_dec(bx_reg) : coord_inc(bx_reg);
    assign ys1 = sub_reg ? coord_dec(by_reg) : coord_inc(by_reg);
    assign zs1 = sub_reg ? coord_inc(bz_reg) : coord_dec(bz_reg);
    assign self_addr = site_addr(sub_reg, bx_reg, by_reg, bz_reg);

    always_comb
    begin
        unique case (cnt_reg)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7:
            begin
                rd_addr = site_addr(!sub_reg, cnt_reg[0] ? xs1 : bx_reg,
                                    cnt_reg[1] ? ys1 : by_reg, cnt_reg[2] ? zs1 : bz_reg);
            end
            4'd8:    rd_addr = site_addr(sub_reg, coord_inc(bx_reg), by_reg, bz_reg);
            4'd9:    rd_addr = site_addr(sub_reg, coord_dec(bx_reg), by_reg, bz_reg);
            4'd10:   rd_addr = site_addr(sub_reg, bx_reg, coord_inc(by_reg), bz_reg);
            4'd11:   rd_addr = site_addr(sub_reg, bx_reg, coord_dec(by_reg), bz_reg);
            4'd12:   rd_addr = site_addr(sub_reg, bx_reg, by_reg, coord_inc(bz_reg));
            4'd13:   rd_addr = site_addr(sub_reg, bx_reg, by_reg, coord_dec(bz_reg));
            default: rd_addr = self_addr;
        endcase
    end

    // ---------------- spin store port ----------------
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    bhm_pkg::spin_t ram_wdata, ram_rdata;
    logic signed [bhm_pkg::SPIN_W-1:0] rd_c [3];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = rd_addr;
        ram_wdata = {prop_reg[2], prop_reg[1], prop_reg[0]};
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = {bhm_pkg::SPIN_ONE, bhm_pkg::SPIN_ZERO, bhm_pkg::SPIN_ZERO};
        end
        else if (state_reg == ST_DONE)
        begin
            ram_we   = done_fire && acc_reg;
            ram_addr = self_addr;
        end
    end

    bhm_ram #(
        .WIDTH (bhm_pkg::SPIN_WORD_W),
        .DEPTH (DEPTH)
    ) u_spin_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_c[0] = ram_rdata.x;
    assign rd_c[1] = ram_rdata.y;
    assign rd_c[2] = ram_rdata.z;

    // ---------------- shared multiplier ----------------
    logic signed [39:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [16:0] diff_c;
    logic signed [PW-1:0] p_sh16, p_sh14;

    assign diff_c = 17'(prop_reg[comp_reg]) - 17'(old_reg[comp_reg]);
    assign p_sh16 = p_reg >>> 16;
    assign p_sh14 = p_reg >>> 14;

    always_comb
    begin
        mul_a = t_reg;
        mul_b = 32'sd0;
        if (state_reg == ST_THR)
        begin
            mul_a = 40'(signed'({1'b0, nlu_reg}));
            mul_b = signed'({1'b0, kt_reg});
        end
        else
        begin
            unique case (step_reg)
                3'd0:
                begin
                    mul_a = 40'(zs_reg[comp_reg]);
                    mul_b = axial_reg;
                end
                3'd2:    mul_b = scale_reg;
                3'd4:    mul_b = coupling_reg;
                3'd6:    mul_b = 32'(diff_c);
                default: mul_b = 32'sd0;
            endcase
        end
    end

    // ---------------- decision and totals ----------------
    logic signed [bhm_pkg::DELTA_W-1:0] delta_f;
    logic                acc_f;
    logic signed [56:0]  energy_sum;
    logic signed [bhm_pkg::TOTAL_W-1:0] energy_new;
    logic signed [MWO-1:0] mag_new [3];

    assign delta_f = -dacc_reg;
    assign acc_f   = (delta_f < 0) ||
                     ((kt_reg != '0) && (PW'(delta_f) <= p_sh16));
    assign energy_sum = 57'(energy_reg) + 57'(delta_reg);

    always_comb
    begin
        if (energy_sum > MAX56)
        begin
            energy_new = MAX56[55:0];
        end
        else if (energy_sum < MIN56)
        begin
            energy_new = MIN56[55:0];
        end
        else
        begin
            energy_new = energy_sum[55:0];
        end
        if (!acc_reg)
        begin
            energy_new = energy_reg;
        end
        for (int c = 0; c < 3; c++)
        begin
            mag_new[c] = acc_reg ? mag_reg[c] + MWO'(17'(prop_reg[c]) - 17'(old_reg[c]))
                                 : mag_reg[c];
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_fire) state_next = ST_READ;
            ST_READ:  if (cnt_reg == RD_END) state_next = ST_CALC;
            ST_CALC:  if (comp_reg == 2'd2 && step_reg == 3'd7) state_next = ST_THR;
            ST_THR:   state_next = ST_DEC;
            ST_DEC:   state_next = ST_DONE;
            ST_DONE:  if (done_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            step_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            rd_n_reg      <= '0;
            out_valid_reg <= 1'b0;
            coupling_reg  <= 32'sd65536;
            field_reg[0]  <= 32'sd0;
            field_reg[1]  <= 32'sd0;
            field_reg[2]  <= 32'sd0;
            axial_reg     <= 32'sd65536;
            scale_reg     <= 32'sd0;
            kt_reg        <= 31'd65536;
            energy_reg    <= '0;
            mag_reg[0]    <= '0;
            mag_reg[1]    <= '0;
            mag_reg[2]    <= MAG_Z_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end

            // read sweep counter
            if (in_fire)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_READ)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
            rd_vld_reg <= (state_reg == ST_READ) && (cnt_reg <= RD_LAST);
            rd_n_reg   <= cnt_reg;

            // component / step counters
            if (state_reg == ST_CALC)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            else
            begin
                step_reg <= '0;
                comp_reg <= '0;
            end

            // output register
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
                energy_reg    <= energy_new;
                mag_reg[0]    <= mag_new[0];
                mag_reg[1]    <= mag_new[1];
                mag_reg[2]    <= mag_new[2];
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // configuration
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bhm_pkg::CFG_COUPLING: coupling_reg <= signed'(cfg_data);
                    bhm_pkg::CFG_FIELD_X:  field_reg[0] <= signed'(cfg_data);
                    bhm_pkg::CFG_FIELD_Y:  field_reg[1] <= signed'(cfg_data);
                    bhm_pkg::CFG_FIELD_Z:  field_reg[2] <= signed'(cfg_data);
                    bhm_pkg::CFG_AXIAL:    axial_reg    <= signed'(cfg_data);
                    bhm_pkg::CFG_SCALE:    scale_reg    <= signed'(cfg_data);
                    bhm_pkg::CFG_KT:       kt_reg       <= cfg_data[bhm_pkg::KT_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        // proposal capture and accumulator clear
        if (in_fire)
        begin
            bx_reg      <= coord_mod(site_x);
            by_reg      <= coord_mod(site_y);
            bz_reg      <= coord_mod(site_z);
            sub_reg     <= sublattice;
            prop_reg[0] <= proposed_x;
            prop_reg[1] <= proposed_y;
            prop_reg[2] <= proposed_z;
            nlu_reg     <= neg_log_uniform;
            dacc_reg    <= '0;
            for (int c = 0; c < 3; c++)
            begin
                nn_reg[c] <= '0;
                n4_reg[c] <= '0;
                zs_reg[c] <= '0;
            end
        end

        // neighbor sums as read data returns
        if (rd_vld_reg)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (rd_n_reg < 4'd8)
                begin
                    nn_reg[c] <= nn_reg[c] + 19'(rd_c[c]);
                end
                else if (rd_n_reg < 4'd12)
                begin
                    n4_reg[c] <= n4_reg[c] + 18'(rd_c[c]);
                end
                else if (rd_n_reg < RD_LAST)
                begin
                    zs_reg[c] <= zs_reg[c] + 17'(rd_c[c]);
                end
                else
                begin
                    old_reg[c] <= rd_c[c];
                end
            end
        end

        // multiplier product
        if (state_reg == ST_CALC || state_reg == ST_THR)
        begin
            p_reg <= mul_a * mul_b;
        end

        // per-component steps between multiplies
        if (state_reg == ST_CALC)
        begin
            unique case (step_reg)
                3'd1:    t_reg <= 40'(n4_reg[comp_reg]) + 40'(p_sh16);
                3'd3:    t_reg <= sat32(PW'(nn_reg[comp_reg]) + p_sh16);
                3'd5:    t_reg <= sat40(p_sh14 + PW'(field_reg[comp_reg]));
                3'd7:    dacc_reg <= dacc_reg + bhm_pkg::DELTA_W'(p_sh14);
                default: ;
            endcase
        end

        if (state_reg == ST_DEC)
        begin
            delta_reg <= delta_f;
            acc_reg   <= acc_f;
        end

        if (done_fire)
        begin
            out_acc_reg    <= acc_reg;
            out_delta_reg  <= delta_reg;
            out_total_reg  <= energy_new;
            out_mag_reg[0] <= mag_new[0][bhm_pkg::MAGNET_OUT_W-1:0];
            out_mag_reg[1] <= mag_new[1][bhm_pkg::MAGNET_OUT_W-1:0];
            out_mag_reg[2] <= mag_new[2][bhm_pkg::MAGNET_OUT_W-1:0];
        end
    end

    assign out_valid           = out_valid_reg;
    assign accepted            = out_acc_reg;
    assign energy_delta        = out_delta_reg;
    assign energy_total_change = out_total_reg;
    assign magnet_x            = out_mag_reg[0];
    assign magnet_y            = out_mag_reg[1];
    assign magnet_z            = out_mag_reg[2];

endmodule

// ----- rtl/core/bhm_checker.sv -----
// bhm_checker: port-level assertions for bcc_heisenberg_metropolis_update, with bind.
// Depends on bhm_pkg.
module bhm_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_stall,
    input logic                                    out_valid,
    input logic                                    out_stall,
    input logic                                    accepted,
    input logic signed [bhm_pkg::DELTA_W-1:0]      energy_delta,
    input logic signed [bhm_pkg::TOTAL_W-1:0]      energy_total_change,
    input logic signed [bhm_pkg::MAGNET_OUT_W-1:0] magnet_x,
    input logic signed [bhm_pkg::MAGNET_OUT_W-1:0] magnet_y,
    input logic signed [bhm_pkg::MAGNET_OUT_W-1:0] magnet_z
);

    // totals of the last delivered item
    logic prev_vld_reg;
    logic signed [bhm_pkg::TOTAL_W-1:0] prev_total_reg;
    logic signed [bhm_pkg::MAGNET_OUT_W-1:0] prev_mx_reg, prev_my_reg, prev_mz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_vld_reg <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            prev_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            prev_total_reg <= energy_total_change;
            prev_mx_reg    <= magnet_x;
            prev_my_reg    <= magnet_y;
            prev_mz_reg    <= magnet_z;
        end
    end

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(energy_delta) && $stable(accepted))
        else $error("stalled result changed");

    // one item at a time: an accepted item blocks the input next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is at work");

    // a rejected move leaves the running totals alone
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted && prev_vld_reg |->
            energy_total_change == prev_total_reg && magnet_x == prev_mx_reg &&
            magnet_y == prev_my_reg && magnet_z == prev_mz_reg)
        else $error("rejected move changed totals");

endmodule

bind bcc_heisenberg_metropolis_update bhm_checker u_bhm_checker (.*);

// ----- tb/bcc_heisenberg_metropolis_update_test.sv -----
`timescale 1ns / 1ps
// Testbench of bcc_heisenberg_metropolis_update: random Metropolis proposals against a
// scoreboard class that keeps its own copy of the lattice, the sums and the registers.
// Depends on bhm_pkg and the block itself.
module bcc_heisenberg_metropolis_update_test;

    localparam int SIDE   = 16;
    localparam int CELLS  = SIDE * SIDE * SIDE;
    localparam int SITES  = 2 * CELLS;
    localparam int DRAIN  = 100;

    typedef struct {
        logic [3:0]                        x;
        logic [3:0]                        y;
        logic [3:0]                        z;
        logic                              sub;
        logic signed [bhm_pkg::SPIN_W-1:0] p [3];
        logic [bhm_pkg::NLU_W-1:0]         nlu;
    } proposal_t;

    typedef struct {
        logic                               acc;
        logic [bhm_pkg::DELTA_W-1:0]        delta;
        logic [bhm_pkg::TOTAL_W-1:0]        total;
        logic [bhm_pkg::MAGNET_OUT_W-1:0]   mag [3];
    } outcome_t;

    // Lattice mirror, running sums and register copy; predicts one outcome per proposal
    class metro_board;
        logic signed [bhm_pkg::SPIN_W-1:0] spins [SITES][3];
        longint energy_sum;
        longint magnet [3];
        longint coupling, field [3], axial, scale, kt;
        outcome_t outcomes [$];
        int errors;

        function void clear();
            for (int n = 0; n < SITES; n++)
            begin
                spins[n][0] = bhm_pkg::SPIN_ZERO;
                spins[n][1] = bhm_pkg::SPIN_ZERO;
                spins[n][2] = bhm_pkg::SPIN_ONE;
            end
            energy_sum = 0;
            magnet[0] = 0;
            magnet[1] = 0;
            magnet[2] = longint'(SITES) * 16384;
            coupling = 65536;
            field[0] = 0;
            field[1] = 0;
            field[2] = 0;
            axial = 65536;
            scale = 0;
            kt = 65536;
            errors = 0;
        endfunction

        function void set_reg(logic [bhm_pkg::CFG_IDX_W-1:0] idx,
                              logic [bhm_pkg::CFG_W-1:0] val);
            case (idx)
                bhm_pkg::CFG_COUPLING: coupling = longint'(signed'(val));
                bhm_pkg::CFG_FIELD_X:  field[0] = longint'(signed'(val));
                bhm_pkg::CFG_FIELD_Y:  field[1] = longint'(signed'(val));
                bhm_pkg::CFG_FIELD_Z:  field[2] = longint'(signed'(val));
                bhm_pkg::CFG_AXIAL:    axial = longint'(signed'(val));
                bhm_pkg::CFG_SCALE:    scale = longint'(signed'(val));
                bhm_pkg::CFG_KT:       kt = longint'(val[bhm_pkg::KT_W-1:0]);
                default:               ;
            endcase
        endfunction

        function longint clamp(longint v, int bits);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (bits - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function int site_of(int sub, int i, int j, int k, int di, int dj, int dk);
            return sub * CELLS + ((i + di + SIDE) % SIDE) * SIDE * SIDE
                 + ((j + dj + SIDE) % SIDE) * SIDE + ((k + dk + SIDE) % SIDE);
        endfunction

        function void note_item(proposal_t it);
            int nn_off [8][3] = '{'{0,0,0},'{1,0,0},'{0,1,0},'{1,1,0},
                                  '{0,0,-1},'{1,0,-1},'{0,1,-1},'{1,1,-1}};
            int sub, other, dir, self, i, j, k;
            int nb [8];
            int sh [6];
            longint delta, nn, nnn, sum, coef, thr;
            outcome_t o;
            sub = int'(it.sub);
            other = 1 - sub;
            dir = sub ? -1 : 1;
            i = int'(it.x);
            j = int'(it.y);
            k = int'(it.z);
            self = site_of(sub, i, j, k, 0, 0, 0);
            for (int n = 0; n < 8; n++)
                nb[n] = site_of(other, i, j, k, nn_off[n][0] * dir, nn_off[n][1] * dir,
                                nn_off[n][2] * dir);
            sh[0] = site_of(sub, i, j, k, 1, 0, 0);
            sh[1] = site_of(sub, i, j, k, -1, 0, 0);
            sh[2] = site_of(sub, i, j, k, 0, 1, 0);
            sh[3] = site_of(sub, i, j, k, 0, -1, 0);
            sh[4] = site_of(sub, i, j, k, 0, 0, 1);
            sh[5] = site_of(sub, i, j, k, 0, 0, -1);
            delta = 0;
            for (int c = 0; c < 3; c++)
            begin
                nn = 0;
                for (int n = 0; n < 8; n++)
                    nn += longint'(spins[nb[n]][c]);
                nnn = longint'(spins[sh[0]][c]) + longint'(spins[sh[1]][c])
                    + longint'(spins[sh[2]][c]) + longint'(spins[sh[3]][c])
                    + ((axial * (longint'(spins[sh[4]][c]) + longint'(spins[sh[5]][c])))
                       >>> 16);
                sum = clamp(nn + ((scale * nnn) >>> 16), 32);
                coef = clamp(((coupling * sum) >>> 14) + field[c], 40);
                delta += (coef * (longint'(it.p[c]) - longint'(spins[self][c]))) >>> 14;
            end
            delta = -delta;
            thr = (kt * longint'(it.nlu)) >>> 16;
            o.acc = (delta < 0) || (kt != 0 && delta <= thr);
            if (o.acc)
            begin
                energy_sum = clamp(energy_sum + delta, 56);
                for (int c = 0; c < 3; c++)
                begin
                    magnet[c] += longint'(it.p[c]) - longint'(spins[self][c]);
                    spins[self][c] = it.p[c];
                end
            end
            o.delta = delta[bhm_pkg::DELTA_W-1:0];
            o.total = energy_sum[bhm_pkg::TOTAL_W-1:0];
            for (int c = 0; c < 3; c++)
                o.mag[c] = magnet[c][bhm_pkg::MAGNET_OUT_W-1:0];
            outcomes.push_back(o);
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check(outcome_t got);
            outcome_t w;
            if (outcomes.size() == 0)
            begin
                report("result with no proposal pending");
                return;
            end
            w = outcomes.pop_front();
            if (got.acc !== w.acc)
                report($sformatf("accepted %b, want %b", got.acc, w.acc));
            if (got.delta !== w.delta)
                report($sformatf("energy_delta %h, want %h", got.delta, w.delta));
            if (got.total !== w.total)
                report($sformatf("energy_total_change %h, want %h", got.total, w.total));
            for (int c = 0; c < 3; c++)
                if (got.mag[c] !== w.mag[c])
                    report($sformatf("magnet[%0d] %h, want %h", c, got.mag[c], w.mag[c]));
        endtask

        function int pending();
            return outcomes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [3:0] site_x;
    logic [3:0] site_y;
    logic [3:0] site_z;
    logic sublattice;
    logic signed [bhm_pkg::SPIN_W-1:0] proposed_x;
    logic signed [bhm_pkg::SPIN_W-1:0] proposed_y;
    logic signed [bhm_pkg::SPIN_W-1:0] proposed_z;
    logic [bhm_pkg::NLU_W-1:0] neg_log_uniform;
    logic out_valid;
    logic out_stall;
    logic accepted;
    logic signed [bhm_pkg::DELTA_W-1:0] energy_delta;
    logic signed [bhm_pkg::TOTAL_W-1:0] energy_total_change;
    logic signed [bhm_pkg::MAGNET_OUT_W-1:0] magnet_x;
    logic signed [bhm_pkg::MAGNET_OUT_W-1:0] magnet_y;
    logic signed [bhm_pkg::MAGNET_OUT_W-1:0] magnet_z;
    logic cfg_write;
    logic [bhm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bhm_pkg::CFG_W-1:0] cfg_data;

    metro_board board = new;
    bit hold_req;
    int burst_left;

    bcc_heisenberg_metropolis_update #(.LATTICE_SIDE(SIDE)) u_dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Time limit: clearing pass plus every item at worst gaps and stalls, several times over
    initial
    begin
        #20ms;
        $display("** bcc_heisenberg_metropolis_update: FAILED **");
        $finish;
    end

    // Receiver: random stalls at a percentage that is redrawn periodically, plus one long hold on request
    initial
    begin
        int cyc;
        int pct;
        int hold_cnt;
        outcome_t got;
        cyc = 0;
        pct = 0;
        hold_cnt = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.acc = accepted;
                got.delta = energy_delta;
                got.total = energy_total_change;
                got.mag[0] = magnet_x;
                got.mag[1] = magnet_y;
                got.mag[2] = magnet_z;
                board.check(got);
            end
            cyc++;
            if (cyc % 256 == 0)
                case ($urandom_range(0, 4))
                    0, 1: pct = 0;
                    2: pct = 25;
                    3: pct = 50;
                    default: pct = 85;
                endcase
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = 400;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < pct);
        end
    end

    // Offer one proposal, after a random gap (possibly none) when the current burst is over
    task send_item(proposal_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        site_x <= it.x;
        site_y <= it.y;
        site_z <= it.z;
        sublattice <= it.sub;
        proposed_x <= it.p[0];
        proposed_y <= it.p[1];
        proposed_z <= it.p[2];
        neg_log_uniform <= it.nlu;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        board.note_item(it);
    endtask

    task write_reg(logic [bhm_pkg::CFG_IDX_W-1:0] idx, logic [bhm_pkg::CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    // Drain the block, then load a full register set
    task load_regs(logic [bhm_pkg::CFG_W-1:0] j, logic [bhm_pkg::CFG_W-1:0] hx,
                   logic [bhm_pkg::CFG_W-1:0] hy, logic [bhm_pkg::CFG_W-1:0] hz,
                   logic [bhm_pkg::CFG_W-1:0] ds, logic [bhm_pkg::CFG_W-1:0] s,
                   logic [bhm_pkg::CFG_W-1:0] kt);
        @(posedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        write_reg(bhm_pkg::CFG_COUPLING, j);
        write_reg(bhm_pkg::CFG_FIELD_X, hx);
        write_reg(bhm_pkg::CFG_FIELD_Y, hy);
        write_reg(bhm_pkg::CFG_FIELD_Z, hz);
        write_reg(bhm_pkg::CFG_AXIAL, ds);
        write_reg(bhm_pkg::CFG_SCALE, s);
        write_reg(bhm_pkg::CFG_KT, kt);
        cfg_write <= 1'b0;
    endtask

    function logic signed [bhm_pkg::SPIN_W-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return bhm_pkg::SPIN_ONE;
            1: return -bhm_pkg::SPIN_ONE;
            2: return bhm_pkg::SPIN_ZERO;
            default: return bhm_pkg::SPIN_W'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // Mostly sites around the lattice corner so neighbors interact and wrap
    function proposal_t rand_item();
        proposal_t it;
        if ($urandom_range(0, 9) < 7)
        begin
            it.x = 4'($urandom_range(0, 2) - 1);
            it.y = 4'($urandom_range(0, 2) - 1);
            it.z = 4'($urandom_range(0, 2) - 1);
        end
        else
        begin
            it.x = 4'($urandom_range(0, 15));
            it.y = 4'($urandom_range(0, 15));
            it.z = 4'($urandom_range(0, 15));
        end
        it.sub = 1'($urandom_range(0, 1));
        for (int c = 0; c < 3; c++)
            it.p[c] = rand_comp();
        case ($urandom_range(0, 9))
            0: it.nlu = '0;
            1: it.nlu = '1;
            2, 3: it.nlu = bhm_pkg::NLU_W'($urandom());
            default: it.nlu = bhm_pkg::NLU_W'($urandom_range(0, 24'h3ffff));
        endcase
        return it;
    endfunction

    function proposal_t make_item(int x, int y, int z, int sub, int px, int py, int pz,
                                  int nlu);
        proposal_t it;
        it.x = 4'(x);
        it.y = 4'(y);
        it.z = 4'(z);
        it.sub = 1'(sub);
        it.p[0] = bhm_pkg::SPIN_W'(px);
        it.p[1] = bhm_pkg::SPIN_W'(py);
        it.p[2] = bhm_pkg::SPIN_W'(pz);
        it.nlu = bhm_pkg::NLU_W'(nlu);
        return it;
    endfunction

    task run_random(int count);
        for (int n = 0; n < count; n++)
            send_item(rand_item());
    endtask

    function logic [bhm_pkg::CFG_W-1:0] rand_small(int lim);
        return bhm_pkg::CFG_W'($urandom_range(0, 2 * lim) - lim);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        site_x = '0;
        site_y = '0;
        site_z = '0;
        sublattice = 1'b0;
        proposed_x = '0;
        proposed_y = '0;
        proposed_z = '0;
        neg_log_uniform = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        burst_left = 0;
        board.clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: corners, both sublattices, extreme spins, no-op, non-unit spin, u extremes
        send_item(make_item(0, 0, 0, 0, 0, 0, 16384, 0));
        send_item(make_item(0, 0, 0, 0, 0, 0, -16384, 0));
        send_item(make_item(0, 0, 0, 0, 0, 0, -16384, 24'hffffff));
        send_item(make_item(15, 15, 15, 1, 16384, 0, 0, 24'hffffff));
        send_item(make_item(15, 15, 15, 1, -16384, 0, 0, 0));
        send_item(make_item(0, 15, 0, 1, 0, -16384, 0, 24'h010000));
        send_item(make_item(15, 0, 15, 0, 0, 16384, 0, 24'h000001));
        send_item(make_item(1, 0, 0, 0, 16384, 16384, 16384, 24'hffffff));
        send_item(make_item(0, 1, 0, 1, -16384, -16384, -16384, 24'hffffff));
        send_item(make_item(0, 0, 1, 0, 0, 0, 0, 24'h7fffff));
        send_item(make_item(0, 0, 15, 1, 11585, -11585, 0, 24'h020000));
        send_item(make_item(8, 8, 8, 0, -1, 1, -1, 24'hffffff));
        send_item(make_item(8, 8, 8, 1, 16384, -16384, 16384, 24'h800000));
        send_item(make_item(15, 15, 0, 0, 0, 0, 16384, 0));
        run_random(60);
        // Long hold on the result side while proposals keep coming
        hold_req = 1'b1;
        run_random(90);

        // kT zero: downhill only; saturating extremes of every register
        load_regs(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h7fffffff, 32'h0);
        send_item(make_item(0, 0, 0, 0, 0, 0, 16384, 24'hffffff));
        send_item(make_item(0, 0, 0, 1, 0, 0, 0, 24'hffffff));
        run_random(110);

        load_regs(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'hffffffff);
        run_random(110);

        load_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffffff);
        run_random(80);

        // Moderate random settings
        for (int ph = 0; ph < 6; ph++)
        begin
            load_regs(rand_small(1 << 18), rand_small(1 << 20), rand_small(1 << 20),
                      rand_small(1 << 20), rand_small(1 << 18), rand_small(1 << 18),
                      (ph == 2) ? 32'h0 : $urandom_range(0, 1 << 19));
            run_random(100);
        end

        @(posedge clk);
        in_valid <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (board.errors == 0)
            $display("** bcc_heisenberg_metropolis_update: PASSED **");
        else
            $display("** bcc_heisenberg_metropolis_update: FAILED **");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/bhm_pkg.sv
rtl/core/bhm_ram.sv
rtl/core/bcc_heisenberg_metropolis_update.sv
rtl/core/bhm_checker.sv
tb/bcc_heisenberg_metropolis_update_test.sv
